[design/cpo_pkg.sv]
package cpo_pkg;

	// Default sizing of the vertex stores and of the coordinates.
	localparam int MAX_VERTICES_DEF = 16;
	localparam int COORD_WIDTH_DEF  = 16;

	// Width of the vertex coordinate ports.
	localparam int VERTEX_BITS = 16;

	// Codes of the separated_by result field.
	localparam logic [1:0] SEP_NONE = 2'd0;
	localparam logic [1:0] SEP_A    = 2'd1;
	localparam logic [1:0] SEP_B    = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr_a;    // store the incoming vertex in polygon A
		logic wr_b;    // store the incoming vertex in polygon B
		logic edge_b;  // the edge under test belongs to polygon B
		logic clr_mm;  // clear the projection intervals
		logic ld_p0;   // capture the first vertex of the edge
		logic ld_nrm;  // form the edge normal from the second vertex
		logic scan;    // a projection read is issued this cycle
		logic first;   // this read is vertex zero
		logic va;      // vertex exists in polygon A
		logic vb;      // vertex exists in polygon B
	} cpo_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic gap;     // the two projection intervals do not touch
	} cpo_status_t;

endpackage

[design/convex_polygon_overlap_test.sv]
// Two-polygon separating-axis test. Each item loads one vertex of polygon A
// or B, and busy stays low between vertices. An item with last_vertex set
// stores its vertex unless that store is full, raises busy and runs the
// test: every edge of A, then of B, projects vertices 0 to k-1 of both
// polygons, where k is the larger vertex count, through the registered vertex
// memories (one read per polygon per cycle) and the four-stage projection
// pipeline. The test ends early at the first separating edge. The single
// result is shown on colliding, separated_by and overflow for exactly one
// cycle with done high; the receiver cannot stall it, so it must take it
// then. Both vertex counts and the overflow flag clear at that point.
module convex_polygon_overlap_test #(
	parameter int MAX_VERTICES = cpo_pkg::MAX_VERTICES_DEF,
	parameter int COORD_WIDTH  = cpo_pkg::COORD_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  polygon_id,
	input  logic signed [cpo_pkg::VERTEX_BITS-1:0] vertex_x,
	input  logic signed [cpo_pkg::VERTEX_BITS-1:0] vertex_y,
	input  logic                                  last_vertex,
	output logic                                  done,
	output logic                                  colliding,
	output logic [1:0]                            separated_by,
	output logic                                  overflow
);

	localparam int AW = $clog2(MAX_VERTICES);

	cpo_pkg::cpo_cmd_t    cmd;
	cpo_pkg::cpo_status_t status;
	logic [AW-1:0]        wr_addr;
	logic [AW-1:0]        rd_addr;

	// Sequencer.
	cpo_ctrl #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.polygon_id  (polygon_id),
		.last_vertex (last_vertex),
		.status      (status),
		.cmd         (cmd),
		.wr_addr     (wr_addr),
		.rd_addr     (rd_addr),
		.busy        (busy),
		.done        (done),
		.colliding   (colliding),
		.separated_by(separated_by),
		.overflow    (overflow)
	);

	// Vertex stores and projection arithmetic.
	cpo_dp #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_WIDTH (COORD_WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr),
		.vertex_x(vertex_x),
		.vertex_y(vertex_y),
		.status  (status)
	);

endmodule

[design/cpo_ram.sv]
module cpo_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/cpo_ctrl.sv]
module cpo_ctrl #(
	parameter int MAX_VERTICES = cpo_pkg::MAX_VERTICES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            polygon_id,
	input  logic                            last_vertex,
	input  cpo_pkg::cpo_status_t            status,
	output cpo_pkg::cpo_cmd_t               cmd,
	output logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
	output logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
	output logic                            busy,
	output logic                            done,
	output logic                            colliding,
	output logic [1:0]                      separated_by,
	output logic                            overflow
);

	localparam int AW   = $clog2(MAX_VERTICES);
	localparam int CNTW = $clog2(MAX_VERTICES + 1);
	localparam logic [CNTW-1:0] CNT_FULL = CNTW'(MAX_VERTICES);
	localparam logic [CNTW-1:0] CNT_ONE  = CNTW'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_NRM_I,
		ST_NRM_J,
		ST_NRM_N,
		ST_SCAN,
		ST_DRAIN,
		ST_CHECK
	} state_t;

	state_t          state_q;
	logic [CNTW-1:0] cnt_a_q;
	logic [CNTW-1:0] cnt_b_q;
	logic            ovf_q;
	logic            edge_b_q;
	logic [AW-1:0]   i_q;
	logic [AW-1:0]   k_q;
	logic [1:0]      drain_q;
	logic            done_q;
	logic            colliding_q;
	logic [1:0]      sep_q;
	logic            ovf_out_q;

	logic            accept;
	logic            full_a;
	logic            full_b;
	logic [CNTW-1:0] n_edge;
	logic [CNTW-1:0] k_max;
	logic            i_last;
	logic            k_last;
	logic [AW-1:0]   j_idx;

	// Edge and scan bookkeeping.
	assign accept = start && (state_q == ST_IDLE);
	assign full_a = (cnt_a_q == CNT_FULL);
	assign full_b = (cnt_b_q == CNT_FULL);
	assign n_edge = edge_b_q ? cnt_b_q : cnt_a_q;
	assign k_max  = (cnt_a_q > cnt_b_q) ? cnt_a_q : cnt_b_q;
	assign i_last = ((CNTW'(i_q) + CNT_ONE) == n_edge);
	assign k_last = ((CNTW'(k_q) + CNT_ONE) == k_max);
	assign j_idx  = i_last ? '0 : (i_q + AW'(1));

	// Commands and addresses for the datapath.
	always_comb begin
		cmd        = '0;
		cmd.wr_a   = accept && !polygon_id && !full_a;
		cmd.wr_b   = accept && polygon_id && !full_b;
		cmd.edge_b = edge_b_q;
		cmd.clr_mm = (state_q == ST_NRM_I);
		cmd.ld_p0  = (state_q == ST_NRM_J);
		cmd.ld_nrm = (state_q == ST_NRM_N);
		cmd.scan   = (state_q == ST_SCAN);
		cmd.first  = (k_q == '0);
		cmd.va     = (CNTW'(k_q) < cnt_a_q);
		cmd.vb     = (CNTW'(k_q) < cnt_b_q);
		wr_addr    = polygon_id ? cnt_b_q[AW-1:0] : cnt_a_q[AW-1:0];
		unique case (state_q)
			ST_NRM_I: rd_addr = i_q;
			ST_NRM_J: rd_addr = j_idx;
			ST_SCAN:  rd_addr = k_q;
			default:  rd_addr = '0;
		endcase
	end

	// Sequencer: loads vertices, walks the edges, and issues the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			ovf_q       <= 1'b0;
			edge_b_q    <= 1'b0;
			i_q         <= '0;
			k_q         <= '0;
			drain_q     <= '0;
			done_q      <= 1'b0;
			colliding_q <= 1'b0;
			sep_q       <= cpo_pkg::SEP_NONE;
			ovf_out_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!polygon_id) begin
							if (full_a) ovf_q <= 1'b1;
							else cnt_a_q <= cnt_a_q + CNT_ONE;
						end else begin
							if (full_b) ovf_q <= 1'b1;
							else cnt_b_q <= cnt_b_q + CNT_ONE;
						end
						if (last_vertex) state_q <= ST_START;
					end
				end
				ST_START: begin
					i_q <= '0;
					if (cnt_a_q != '0) begin
						edge_b_q <= 1'b0;
						state_q  <= ST_NRM_I;
					end else if (cnt_b_q != '0) begin
						edge_b_q <= 1'b1;
						state_q  <= ST_NRM_I;
					end else begin
						// Both polygons empty: nothing can separate them.
						done_q      <= 1'b1;
						colliding_q <= 1'b1;
						sep_q       <= cpo_pkg::SEP_NONE;
						ovf_out_q   <= ovf_q;
						cnt_a_q     <= '0;
						cnt_b_q     <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				ST_NRM_I: state_q <= ST_NRM_J;
				ST_NRM_J: state_q <= ST_NRM_N;
				ST_NRM_N: begin
					k_q     <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (k_last) begin
						drain_q <= '0;
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					if (drain_q == 2'd2) state_q <= ST_CHECK;
					else drain_q <= drain_q + 2'd1;
				end
				ST_CHECK: begin
					if (status.gap) begin
						done_q      <= 1'b1;
						colliding_q <= 1'b0;
						sep_q       <= edge_b_q ? cpo_pkg::SEP_B : cpo_pkg::SEP_A;
						ovf_out_q   <= ovf_q;
						cnt_a_q     <= '0;
						cnt_b_q     <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end else if (!i_last) begin
						i_q     <= i_q + AW'(1);
						state_q <= ST_NRM_I;
					end else if (!edge_b_q && (cnt_b_q != '0)) begin
						edge_b_q <= 1'b1;
						i_q      <= '0;
						state_q  <= ST_NRM_I;
					end else begin
						done_q      <= 1'b1;
						colliding_q <= 1'b1;
						sep_q       <= cpo_pkg::SEP_NONE;
						ovf_out_q   <= ovf_q;
						cnt_a_q     <= '0;
						cnt_b_q     <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign colliding    = colliding_q;
	assign separated_by = sep_q;
	assign overflow     = ovf_out_q;

endmodule

[design/cpo_dp.sv]
module cpo_dp #(
	parameter int MAX_VERTICES = cpo_pkg::MAX_VERTICES_DEF,
	parameter int COORD_WIDTH  = cpo_pkg::COORD_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cpo_pkg::cpo_cmd_t                     cmd,
	input  logic [$clog2(MAX_VERTICES)-1:0]       wr_addr,
	input  logic [$clog2(MAX_VERTICES)-1:0]       rd_addr,
	input  logic signed [cpo_pkg::VERTEX_BITS-1:0] vertex_x,
	input  logic signed [cpo_pkg::VERTEX_BITS-1:0] vertex_y,
	output cpo_pkg::cpo_status_t                  status
);

	localparam int CW  = COORD_WIDTH;
	localparam int XW  = (CW > cpo_pkg::VERTEX_BITS) ? CW : cpo_pkg::VERTEX_BITS;
	localparam int DW  = 2 * CW;
	localparam int NW  = CW + 1;
	localparam int PRW = 2 * CW + 1;
	localparam int PW  = 2 * CW + 2;

	logic [XW-1:0]        x_ext;
	logic [XW-1:0]        y_ext;
	logic [DW-1:0]        wdata;
	logic [DW-1:0]        rdata_a;
	logic [DW-1:0]        rdata_b;
	logic signed [CW-1:0] xa;
	logic signed [CW-1:0] ya;
	logic signed [CW-1:0] xb;
	logic signed [CW-1:0] yb;
	logic signed [CW-1:0] ex;
	logic signed [CW-1:0] ey;

	logic signed [CW-1:0] p0x_q;
	logic signed [CW-1:0] p0y_q;
	logic signed [NW-1:0] nx_q;
	logic signed [NW-1:0] ny_q;

	logic                  va_s1, vb_s1, first_s1;
	logic                  va_s2, vb_s2, first_s2;
	logic                  va_s3, vb_s3, first_s3;
	logic signed [PRW-1:0] pax_s2, pay_s2, pbx_s2, pby_s2;
	logic signed [PW-1:0]  pa_s3, pb_s3;
	logic signed [PW-1:0]  mina_q, maxa_q, minb_q, maxb_q;

	// Coordinates are the low COORD_WIDTH bits of the port, zero-extended if the port is narrower, taken as signed.
	assign x_ext = XW'($unsigned(vertex_x));
	assign y_ext = XW'($unsigned(vertex_y));
	assign wdata = {x_ext[CW-1:0], y_ext[CW-1:0]};

	cpo_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_VERTICES)
	) u_ram_a (
		.clk  (clk),
		.we   (cmd.wr_a),
		.waddr(wr_addr),
		.wdata(wdata),
		.raddr(rd_addr),
		.rdata(rdata_a)
	);

	cpo_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_VERTICES)
	) u_ram_b (
		.clk  (clk),
		.we   (cmd.wr_b),
		.waddr(wr_addr),
		.wdata(wdata),
		.raddr(rd_addr),
		.rdata(rdata_b)
	);

	assign xa = $signed(rdata_a[DW-1:CW]);
	assign ya = $signed(rdata_a[CW-1:0]);
	assign xb = $signed(rdata_b[DW-1:CW]);
	assign yb = $signed(rdata_b[CW-1:0]);
	assign ex = cmd.edge_b ? xb : xa;
	assign ey = cmd.edge_b ? yb : ya;

	// Edge normal: (y2 - y1, x1 - x2), formed over two reads.
	always_ff @(posedge clk) begin
		if (cmd.ld_p0) begin
			p0x_q <= ex;
			p0y_q <= ey;
		end
		if (cmd.ld_nrm) begin
			nx_q <= NW'(ey) - NW'(p0y_q);
			ny_q <= NW'(p0x_q) - NW'(ex);
		end
	end

	// Projection pipeline control: read data, products, sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_s1    <= 1'b0;
			vb_s1    <= 1'b0;
			first_s1 <= 1'b0;
			va_s2    <= 1'b0;
			vb_s2    <= 1'b0;
			first_s2 <= 1'b0;
			va_s3    <= 1'b0;
			vb_s3    <= 1'b0;
			first_s3 <= 1'b0;
		end else begin
			va_s1    <= cmd.scan && cmd.va;
			vb_s1    <= cmd.scan && cmd.vb;
			first_s1 <= cmd.scan && cmd.first;
			va_s2    <= va_s1;
			vb_s2    <= vb_s1;
			first_s2 <= first_s1;
			va_s3    <= va_s2;
			vb_s3    <= vb_s2;
			first_s3 <= first_s2;
		end
	end

	// Projection pipeline data.
	always_ff @(posedge clk) begin
		pax_s2 <= nx_q * xa;
		pay_s2 <= ny_q * ya;
		pbx_s2 <= nx_q * xb;
		pby_s2 <= ny_q * yb;
		pa_s3  <= PW'(pax_s2) + PW'(pay_s2);
		pb_s3  <= PW'(pbx_s2) + PW'(pby_s2);
	end

	// Running min/max of each polygon's projections; an empty polygon stays at zero.
	always_ff @(posedge clk) begin
		if (cmd.clr_mm) begin
			mina_q <= '0;
			maxa_q <= '0;
			minb_q <= '0;
			maxb_q <= '0;
		end else begin
			if (va_s3) begin
				if (first_s3 || (pa_s3 < mina_q)) mina_q <= pa_s3;
				if (first_s3 || (pa_s3 > maxa_q)) maxa_q <= pa_s3;
			end
			if (vb_s3) begin
				if (first_s3 || (pb_s3 < minb_q)) minb_q <= pb_s3;
				if (first_s3 || (pb_s3 > maxb_q)) maxb_q <= pb_s3;
			end
		end
	end

	// A strict gap between the intervals separates the polygons.
	assign status.gap = (maxa_q < minb_q) || (maxb_q < mina_q);

endmodule

[design/cpo_checker.sv]
module cpo_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       last_vertex,
	input logic       done,
	input logic       colliding,
	input logic [1:0] separated_by
);

	// A result says colliding exactly when no edge separated the polygons.
	a_colliding_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (colliding == (separated_by == cpo_pkg::SEP_NONE)))
		else $error("colliding disagrees with separated_by");

	// A result never carries an unused separation code.
	a_sep_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((separated_by == cpo_pkg::SEP_NONE) ||
			(separated_by == cpo_pkg::SEP_A) || (separated_by == cpo_pkg::SEP_B)))
		else $error("separated_by holds an unused code");

	// A closing item starts a test.
	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_vertex) |=> busy)
		else $error("closing item did not start a test");

	// A plain vertex item neither blocks the block nor makes a result.
	a_plain_item: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !last_vertex) |=> (!busy && !done))
		else $error("vertex item caused busy or a result");

	// A result only ends a test.
	a_done_after_test: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a preceding test");

endmodule

bind convex_polygon_overlap_test cpo_checker u_cpo_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.last_vertex (last_vertex),
	.done        (done),
	.colliding   (colliding),
	.separated_by(separated_by)
);

[tb/convex_polygon_overlap_test_tb.sv]
`timescale 1ns / 1ps

module convex_polygon_overlap_test_tb;

	localparam int MAXV        = cpo_pkg::MAX_VERTICES_DEF;
	localparam int SHAPE_MAX   = 24;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 800;

	// One vertex as presented on the input ports.
	typedef struct packed {
		logic                                   pid;
		logic signed [cpo_pkg::VERTEX_BITS-1:0] x;
		logic signed [cpo_pkg::VERTEX_BITS-1:0] y;
		logic                                   closes;
	} vertex_item_t;

	// One overlap verdict as shown on the result ports.
	typedef struct packed {
		logic       colliding;
		logic [1:0] sep;
		logic       spill;
	} verdict_t;

	logic                                   clk = 1'b0;
	logic                                   arst_n = 1'b0;
	logic                                   start = 1'b0;
	logic                                   busy;
	logic                                   polygon_id = 1'b0;
	logic signed [cpo_pkg::VERTEX_BITS-1:0] vertex_x = '0;
	logic signed [cpo_pkg::VERTEX_BITS-1:0] vertex_y = '0;
	logic                                   last_vertex = 1'b0;
	logic                                   done;
	logic                                   colliding;
	logic [1:0]                             separated_by;
	logic                                   overflow;

	vertex_item_t vertex_queue[$];
	verdict_t     pending_verdicts[$];
	vertex_item_t cur;
	verdict_t     want;

	// Predicted contents of the two vertex stores.
	int poly_x[2][MAXV];
	int poly_y[2][MAXV];
	int poly_n[2];
	bit spill_seen;

	// Scratch shapes used while building stimulus.
	int shape_x[2][SHAPE_MAX];
	int shape_y[2][SHAPE_MAX];

	int  total_items;
	int  items_taken;
	int  items_issued;
	int  mismatches;
	int  cycle_count;
	int  verdict_count;
	bit  item_taken;

	convex_polygon_overlap_test dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.polygon_id   (polygon_id),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.last_vertex  (last_vertex),
		.done         (done),
		.colliding    (colliding),
		.separated_by (separated_by),
		.overflow     (overflow)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Interval of one polygon projected on the axis (nx, ny); empty gives zero.
	function automatic void project_span(int p, longint nx, longint ny,
			output longint lo, output longint hi);
		longint d;
		lo = 0;
		hi = 0;
		for (int i = 0; i < poly_n[p]; i++) begin
			d = longint'(poly_x[p][i]) * nx + longint'(poly_y[p][i]) * ny;
			if (i == 0 || d < lo) lo = d;
			if (i == 0 || d > hi) hi = d;
		end
	endfunction

	// True when some edge normal of polygon p shows a strict gap.
	function automatic bit edge_splits(int p);
		int     j;
		longint nx, ny, lo_p, hi_p, lo_q, hi_q;
		for (int i = 0; i < poly_n[p]; i++) begin
			j = (i + 1 == poly_n[p]) ? 0 : i + 1;
			nx = longint'(poly_y[p][j]) - longint'(poly_y[p][i]);
			ny = longint'(poly_x[p][i]) - longint'(poly_x[p][j]);
			project_span(p, nx, ny, lo_p, hi_p);
			project_span(1 - p, nx, ny, lo_q, hi_q);
			if (hi_p < lo_q || hi_q < lo_p) return 1'b1;
		end
		return 1'b0;
	endfunction

	// Store an accepted vertex; a closing vertex also yields the verdict.
	function automatic void absorb_vertex(logic pid,
			logic signed [cpo_pkg::VERTEX_BITS-1:0] x,
			logic signed [cpo_pkg::VERTEX_BITS-1:0] y, logic closes);
		verdict_t v;
		int       p;
		p = pid;
		if (poly_n[p] < MAXV) begin
			poly_x[p][poly_n[p]] = int'(x);
			poly_y[p][poly_n[p]] = int'(y);
			poly_n[p]++;
		end else begin
			spill_seen = 1'b1;
		end
		if (closes) begin
			if (edge_splits(0)) v.sep = cpo_pkg::SEP_A;
			else if (edge_splits(1)) v.sep = cpo_pkg::SEP_B;
			else v.sep = cpo_pkg::SEP_NONE;
			v.colliding = (v.sep == cpo_pkg::SEP_NONE);
			v.spill = spill_seen;
			pending_verdicts = {pending_verdicts, v};
			poly_n[0] = 0;
			poly_n[1] = 0;
			spill_seen = 1'b0;
		end
	endfunction

	task automatic push_vertex(bit p, int x, int y, bit closes);
		vertex_item_t it;
		it.pid = p;
		it.x = x[cpo_pkg::VERTEX_BITS-1:0];
		it.y = y[cpo_pkg::VERTEX_BITS-1:0];
		it.closes = closes;
		vertex_queue = {vertex_queue, it};
	endtask

	function automatic int clamp_coord(int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic int signed_pick(int w);
		return $urandom_range(0, 2 * w) - w;
	endfunction

	// Convex shape: points on a circle in increasing angle order.
	task automatic build_convex(int p, int n, int cx, int cy, int r);
		int  step;
		int  base;
		int  deg;
		real ang;
		step = 360 / n;
		base = $urandom_range(0, 359);
		for (int k = 0; k < n; k++) begin
			deg = base + k * step + $urandom_range(0, step * 4 / 5);
			ang = deg * 3.14159265358979 / 180.0;
			shape_x[p][k] = clamp_coord(cx + int'(r * $cos(ang)));
			shape_y[p][k] = clamp_coord(cy + int'(r * $sin(ang)));
		end
	endtask

	// Arbitrary points: full-range bits, small values near zero, or extremes.
	task automatic build_noise(int p, int n);
		int mode;
		for (int k = 0; k < n; k++) begin
			mode = $urandom_range(0, 2);
			if (mode == 0) begin
				shape_x[p][k] = int'($urandom);
				shape_y[p][k] = int'($urandom);
			end else if (mode == 1) begin
				shape_x[p][k] = signed_pick(20);
				shape_y[p][k] = signed_pick(20);
			end else begin
				shape_x[p][k] = $urandom_range(0, 1) ? 32767 : -32768;
				shape_y[p][k] = $urandom_range(0, 1) ? 32767 : -32768;
			end
		end
	endtask

	// Mostly small polygons, now and then large, empty or overfilled ones.
	function automatic int pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return 0;
		if (r < 80) return $urandom_range(1, 6);
		if (r < 94) return $urandom_range(7, MAXV);
		return $urandom_range(MAXV + 1, 20);
	endfunction

	// One full test: both polygons interleaved, the final vertex closes it.
	task automatic queue_test(bit neat);
		int n[2];
		int k[2];
		int w;
		int r[2];
		int cx;
		int cy;
		int span;
		int sel;
		bit p;
		n[0] = pick_count();
		n[1] = pick_count();
		if (n[0] + n[1] == 0) n[$urandom_range(0, 1)] = 1;
		if (neat) begin
			sel = $urandom_range(0, 99);
			if (sel < 15) w = 4;
			else if (sel < 65) w = 60;
			else if (sel < 90) w = 1000;
			else w = 14000;
			r[0] = $urandom_range(1, w);
			r[1] = $urandom_range(1, w);
			cx = signed_pick(w);
			cy = signed_pick(w);
			span = r[0] + r[1] + w / 4;
			for (int q = 0; q < 2; q++) begin
				if (n[q] != 0) begin
					if (q == 0) build_convex(0, n[0], cx, cy, r[0]);
					else build_convex(1, n[1], cx + signed_pick(span),
						cy + signed_pick(span), r[1]);
				end
			end
		end else begin
			build_noise(0, n[0]);
			build_noise(1, n[1]);
		end
		k[0] = 0;
		k[1] = 0;
		while (k[0] < n[0] || k[1] < n[1]) begin
			if (k[0] == n[0]) p = 1'b1;
			else if (k[1] == n[1]) p = 1'b0;
			else p = $urandom_range(0, 1);
			push_vertex(p, shape_x[p][k[p]], shape_y[p][k[p]],
				k[0] + k[1] + 1 == n[0] + n[1]);
			k[p]++;
		end
	endtask

	// Driver: presents the next item at the falling edge once the last one was taken.
	always @(negedge clk) begin
		if (arst_n && (!start || item_taken)) begin
			item_taken = 1'b0;
			if (vertex_queue.size() != 0 &&
					!((items_issued < 300 || items_issued >= 450) &&
					$urandom_range(0, 99) < 6)) begin
				cur = vertex_queue.pop_front();
				items_issued++;
				start <= 1'b1;
				polygon_id <= cur.pid;
				vertex_x <= cur.x;
				vertex_y <= cur.y;
				last_vertex <= cur.closes;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: checks each strobed verdict, then records any item taken at this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				verdict_count++;
				if (pending_verdicts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result: colliding=%0d separated_by=%0d overflow=%0d",
							colliding, separated_by, overflow);
				end else begin
					want = pending_verdicts.pop_front();
					if (colliding !== want.colliding || separated_by !== want.sep ||
							overflow !== want.spill) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Result %0d: expected colliding=%0d separated_by=%0d ",
								verdict_count, want.colliding, want.sep,
								"overflow=%0d, got colliding=%0d separated_by=%0d ",
								want.spill, colliding, separated_by,
								"overflow=%0d", overflow);
					end
				end
			end
			if (start && !busy) begin
				absorb_vertex(polygon_id, vertex_x, vertex_y, last_vertex);
				items_taken++;
				item_taken = 1'b1;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		poly_n[0] = 0;
		poly_n[1] = 0;
		spill_seen = 1'b0;

		// Lone vertex of A at the coordinate extremes; B empty.
		push_vertex(0, -32768, 32767, 1);
		// Lone vertex of B; A empty.
		push_vertex(1, 32767, -32768, 1);
		// A is a single point, so only an edge of B can separate.
		push_vertex(0, 100, 100, 0);
		push_vertex(1, 0, 0, 0);
		push_vertex(1, 10, 0, 0);
		push_vertex(1, 0, 10, 1);
		// Squares sharing an edge: touching intervals do not separate.
		push_vertex(0, 0, 0, 0);
		push_vertex(1, 10, 0, 0);
		push_vertex(0, 10, 0, 0);
		push_vertex(1, 20, 0, 0);
		push_vertex(0, 10, 10, 0);
		push_vertex(1, 20, 10, 0);
		push_vertex(0, 0, 10, 0);
		push_vertex(1, 10, 10, 1);
		// Triangles in opposite corners of the coordinate range.
		push_vertex(0, -32768, -32768, 0);
		push_vertex(0, -32000, -32768, 0);
		push_vertex(0, -32768, -32000, 0);
		push_vertex(1, 32767, 32767, 0);
		push_vertex(1, 32000, 32767, 0);
		push_vertex(1, 32767, 32000, 1);

		// Random tests: mostly convex pairs, the rest arbitrary points.
		while (vertex_queue.size() < 740) queue_test($urandom_range(0, 99) < 80);
		total_items = vertex_queue.size();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (items_taken < total_items || pending_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
